### rtl/srpd_pkg.sv
// Package: constants, codes and the angle-to-width table for the servo ramp driver.
`default_nettype none
package srpd_pkg;

  localparam int MIN_PULSE = 500;
  localparam int MAX_PULSE = 2500;
  localparam int ANGLE_FULL = 180;
  localparam int ANGLE_HALF = 90;

  localparam int WIDTH_W = 12;
  localparam int SPEED_W = 8;
  localparam int ANGLE_W = 8;
  localparam int FUNC_W = 2;
  localparam int CAL_W = 10;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 12;

  localparam logic [ANGLE_W-1:0] ANGLE_LIMIT = ANGLE_W'(ANGLE_FULL);
  localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'((MIN_PULSE + MAX_PULSE) / 2);
  localparam logic [WIDTH_W-1:0] WIDTH_MAX = '1;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK   = 2'd0,
    FUNC_TARGET = 2'd1,
    FUNC_JUMP   = 2'd2
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIRROR      = 3'd0,
    CFG_CALIBRATION = 3'd1,
    CFG_MIN_SPEED   = 3'd2,
    CFG_MAX_SPEED   = 3'd3,
    CFG_ACCEL       = 3'd4,
    CFG_DECEL       = 3'd5,
    CFG_DECEL_ZONE  = 3'd6
  } cfg_idx_t;

  typedef logic [WIDTH_W-1:0] width_tab_t [0:(1 << ANGLE_W) - 1];

  function automatic int angle_to_width(int a);
    int num;
    num = MIN_PULSE * ANGLE_FULL + a * (MAX_PULSE - MIN_PULSE);
    return num / ANGLE_FULL;
  endfunction

  function automatic width_tab_t build_width_table();
    width_tab_t tab;
    for (int i = 0; i < (1 << ANGLE_W); i++) begin
      tab[i] = (i <= ANGLE_FULL) ? WIDTH_W'(angle_to_width(i)) : '0;
    end
    return tab;
  endfunction

  localparam width_tab_t WIDTH_TABLE = build_width_table();
  localparam int MIRROR_SUM = 2 * angle_to_width(ANGLE_HALF);

endpackage
`default_nettype wire

### rtl/srpd_in_if.sv
// Input channel: command words (func, angle) with valid/ready.
`default_nettype none
interface srpd_in_if
  import srpd_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [FUNC_W-1:0]  func;
  logic [ANGLE_W-1:0] angle;

  modport source (output valid, func, angle, input ready);
  modport sink (input valid, func, angle, output ready);
endinterface
`default_nettype wire

### rtl/srpd_out_if.sv
// Result channel: pulse words with valid/ready.
`default_nettype none
interface srpd_out_if
  import srpd_pkg::*;
;
  logic               valid;
  logic               ready;
  logic               pulse_valid;
  logic [WIDTH_W-1:0] pulse_width;
  logic               move_done;
  logic [SPEED_W-1:0] cur_speed;

  modport source (output valid, pulse_valid, pulse_width, move_done, cur_speed, input ready);
  modport sink (input valid, pulse_valid, pulse_width, move_done, cur_speed, output ready);
endinterface
`default_nettype wire

### rtl/servo_ramped_position_driver.sv
// Top level: servo pulse-width driver with speed ramp; one command word per cycle unless stalled.
//
//   channel  dir  handshake             payload
//   in_ch    in   valid/ready           func[1:0], angle[7:0]
//   out_ch   out  valid/ready           pulse_valid, pulse_width[11:0], move_done, cur_speed[7:0]
//   cfg_*    in   cfg_we (no stall)     cfg_index[2:0], cfg_data[11:0]
//
// One word per cycle sustained unless out_ch stalls; input register, then result register.
// The state update runs in one pass between the input register and the result register.
// Synchronous active-low reset; state returns to mid width, speed 1, move finished.
// A stalled result holds the input register; in_ch.ready drops only when both are full.
`default_nettype none
module servo_ramped_position_driver
  import srpd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  srpd_in_if.sink                    in_ch,
  srpd_out_if.source                 out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic               mirror_r;
  logic [CAL_W-1:0]   calib_r;
  logic [SPEED_W-1:0] min_speed_r;
  logic [SPEED_W-1:0] max_speed_r;
  logic [SPEED_W-1:0] accel_r;
  logic [SPEED_W-1:0] decel_r;
  logic [WIDTH_W-1:0] zone_r;

  logic               in_valid_r;
  logic [FUNC_W-1:0]  in_func_r;
  logic [ANGLE_W-1:0] in_angle_r;

  logic [WIDTH_W-1:0] cur_width_r, cur_width_nxt;
  logic [WIDTH_W-1:0] tgt_width_r, tgt_width_nxt;
  logic [SPEED_W-1:0] speed_r, speed_nxt;
  logic               finished_r, finished_nxt;

  logic               out_valid_r;
  logic               pulse_valid_r, pulse_valid_nxt;
  logic [WIDTH_W-1:0] pulse_width_r, pulse_width_nxt;
  logic               move_done_r;
  logic [SPEED_W-1:0] cur_speed_r;

  logic               out_free;
  logic               advance;
  logic               in_accept;

  assign out_free  = !out_valid_r || out_ch.ready;
  assign advance   = in_valid_r && out_free;
  assign in_ch.ready = !in_valid_r || out_free;
  assign in_accept = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mirror_r    <= 1'b0;
      calib_r     <= '0;
      min_speed_r <= SPEED_W'(1);
      max_speed_r <= SPEED_W'(20);
      accel_r     <= SPEED_W'(1);
      decel_r     <= SPEED_W'(1);
      zone_r      <= WIDTH_W'(100);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MIRROR:      mirror_r    <= cfg_data[0];
        CFG_CALIBRATION: calib_r     <= cfg_data[CAL_W-1:0];
        CFG_MIN_SPEED:   min_speed_r <= cfg_data[SPEED_W-1:0];
        CFG_MAX_SPEED:   max_speed_r <= cfg_data[SPEED_W-1:0];
        CFG_ACCEL:       accel_r     <= cfg_data[SPEED_W-1:0];
        CFG_DECEL:       decel_r     <= cfg_data[SPEED_W-1:0];
        CFG_DECEL_ZONE:  zone_r      <= cfg_data[WIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_accept) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_func_r  <= in_ch.func;
      in_angle_r <= in_ch.angle;
    end
  end

  always_comb begin
    logic signed [13:0] diff;
    logic signed [13:0] zone_s;
    logic signed [10:0] spd_s;
    logic signed [13:0] spd_e;
    logic signed [13:0] step;
    logic signed [13:0] gap;
    logic signed [14:0] drv;
    logic               angle_ok;
    logic [WIDTH_W-1:0] map_width;

    angle_ok  = in_angle_r <= ANGLE_LIMIT;
    map_width = WIDTH_TABLE[in_angle_r];

    cur_width_nxt   = cur_width_r;
    tgt_width_nxt   = tgt_width_r;
    speed_nxt       = speed_r;
    finished_nxt    = finished_r;
    pulse_valid_nxt = 1'b0;

    diff   = $signed({2'b00, cur_width_r}) - $signed({2'b00, tgt_width_r});
    zone_s = $signed({2'b00, zone_r});
    if (diff > -zone_s && diff < zone_s) begin
      spd_s = $signed({3'b000, speed_r}) - $signed({3'b000, decel_r});
    end else begin
      spd_s = $signed({3'b000, speed_r}) + $signed({3'b000, accel_r});
    end
    if (spd_s < $signed({3'b000, min_speed_r})) begin
      spd_s = $signed({3'b000, min_speed_r});
    end
    if (spd_s > $signed({3'b000, max_speed_r})) begin
      spd_s = $signed({3'b000, max_speed_r});
    end
    spd_e = $signed({6'b000000, spd_s[SPEED_W-1:0]});

    if (cur_width_r > tgt_width_r) begin
      step = $signed({2'b00, cur_width_r}) - spd_e;
    end else begin
      step = $signed({2'b00, cur_width_r}) + spd_e;
    end
    gap = step - $signed({2'b00, tgt_width_r});

    unique case (func_t'(in_func_r))
      FUNC_TICK: begin
        speed_nxt = spd_s[SPEED_W-1:0];
        if (!finished_r) begin
          pulse_valid_nxt = 1'b1;
          priority if (gap > -spd_e && gap < spd_e) begin
            cur_width_nxt = tgt_width_r;
          end else if (step < 14'sd0) begin
            cur_width_nxt = '0;
          end else if (step > $signed({2'b00, WIDTH_MAX})) begin
            cur_width_nxt = WIDTH_MAX;
          end else begin
            cur_width_nxt = step[WIDTH_W-1:0];
          end
          finished_nxt = cur_width_nxt == tgt_width_r;
        end
      end
      FUNC_TARGET: begin
        if (angle_ok) begin
          tgt_width_nxt = map_width;
          finished_nxt  = 1'b0;
        end
      end
      FUNC_JUMP: begin
        if (angle_ok) begin
          tgt_width_nxt   = map_width;
          cur_width_nxt   = map_width;
          pulse_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase

    if (mirror_r) begin
      drv = 15'(MIRROR_SUM) - $signed({3'b000, cur_width_nxt});
    end else begin
      drv = $signed({3'b000, cur_width_nxt});
    end
    drv = drv + 15'(signed'(calib_r));
    priority if (drv < 15'sd0) begin
      pulse_width_nxt = '0;
    end else if (drv > $signed({3'b000, WIDTH_MAX})) begin
      pulse_width_nxt = WIDTH_MAX;
    end else begin
      pulse_width_nxt = drv[WIDTH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_width_r <= WIDTH_RESET;
      tgt_width_r <= WIDTH_RESET;
      speed_r     <= SPEED_W'(1);
      finished_r  <= 1'b1;
    end else if (advance) begin
      cur_width_r <= cur_width_nxt;
      tgt_width_r <= tgt_width_nxt;
      speed_r     <= speed_nxt;
      finished_r  <= finished_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pulse_valid_r <= pulse_valid_nxt;
      pulse_width_r <= pulse_width_nxt;
      move_done_r   <= finished_nxt;
      cur_speed_r   <= speed_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.pulse_valid = pulse_valid_r;
  assign out_ch.pulse_width = pulse_width_r;
  assign out_ch.move_done   = move_done_r;
  assign out_ch.cur_speed   = cur_speed_r;

`ifndef ASSERT_OFF
  a_finished_at_target: assert property (@(posedge clk) disable iff (!rst_n)
    finished_r |-> cur_width_r == tgt_width_r)
    else $error("finished flag set away from target");

  a_state_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(cur_width_r) && $stable(speed_r) && $stable(finished_r))
    else $error("state moved without an advance");

  a_done_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r && move_done_r == finished_r && cur_speed_r == speed_r)
    else $error("result word disagrees with state");
`endif

endmodule
`default_nettype wire
